// ===== rtl/core/nearest_downscale_gray_defines.svh =====
// ----------------------------------------------------------------------------
// nearest_downscale_gray_defines.svh
// Assertion macros for the downscaler queue module. They sample on clk and
// are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_DOWNSCALE_GRAY_DEFINES_SVH
`define NEAREST_DOWNSCALE_GRAY_DEFINES_SVH

// Check that a condition holds at every clock edge out of reset.
`define NDG_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a consequence holds in the cycle after its trigger.
`define NDG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ndg_pkg.sv =====
// ----------------------------------------------------------------------------
// ndg_pkg
// Shared types, register codes and the gray conversion for the downscaler.
// ----------------------------------------------------------------------------
package ndg_pkg;

	// Default largest source or destination dimension
	localparam int MAX_DIM_DEF = 4096;

	// Configuration field widths
	localparam int SRC_WIDTH_W = 13;
	localparam int COL_STEP_W  = 29;
	localparam int DEST_COLS_W = 13;
	localparam int ROW_SCALE_W = 17;
	localparam int OFFSET_W    = 12;
	localparam int COORD_W     = 13;
	localparam int SAMPLE_W    = 30;
	localparam int PIXEL_W     = 16;
	localparam int GRAY_W      = 8;

	// Fixed point constants
	localparam int ONE_Q16    = 65536;
	localparam int SAMPLE_MAX = 30'h3FFF_FFFF;

	// Luminance weights and shift
	localparam int GRAY_WR    = 38;
	localparam int GRAY_WG    = 75;
	localparam int GRAY_WB    = 15;
	localparam int GRAY_SHIFT = 7;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Register map
	localparam int REG_IDX_W = 3;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_SOURCE_WIDTH  = 3'd0,
		REG_COL_STEP      = 3'd1,
		REG_DEST_COLS     = 3'd2,
		REG_ROW_SCALE     = 3'd3,
		REG_DEST_LEFT     = 3'd4,
		REG_DEST_TOP      = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [SRC_WIDTH_W-1:0] source_width;
		logic [COL_STEP_W-1:0]  col_step_q16;
		logic [DEST_COLS_W-1:0] dest_cols;
		logic [ROW_SCALE_W-1:0] row_scale_q16;
		logic [OFFSET_W-1:0]    dest_left;
		logic [OFFSET_W-1:0]    dest_top;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] dest_x;
		logic [COORD_W-1:0] dest_y;
		logic [PIXEL_W-1:0] pixel;
	} q_item_t;

	// Weighted luminance of an RGB565 pixel
	function automatic logic [GRAY_W-1:0] gray_of(input logic [PIXEL_W-1:0] p);
		logic [15:0] r;
		logic [15:0] g;
		logic [15:0] b;
		logic [15:0] s;
		r = {8'd0, p[15:11], 3'b000};
		g = {8'd0, p[10:5], 2'b00};
		b = {8'd0, p[4:0], 3'b000};
		s = r * 16'(GRAY_WR) + g * 16'(GRAY_WG) + b * 16'(GRAY_WB);
		s = s >> GRAY_SHIFT;
		return s[GRAY_W-1:0];
	endfunction

endpackage

// ===== rtl/core/ndg_regs.sv =====
// ----------------------------------------------------------------------------
// ndg_regs
// APB configuration registers of the downscaler, with read back.
// ----------------------------------------------------------------------------
module ndg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output ndg_pkg::cfg_t cfg
);
	import ndg_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write the addressed register on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_width  <= SRC_WIDTH_W'(1);
			cfg_q.col_step_q16  <= COL_STEP_W'(ONE_Q16);
			cfg_q.dest_cols     <= '0;
			cfg_q.row_scale_q16 <= ROW_SCALE_W'(ONE_Q16);
			cfg_q.dest_left     <= '0;
			cfg_q.dest_top      <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_SOURCE_WIDTH: cfg_q.source_width  <= pwdata[SRC_WIDTH_W-1:0];
				REG_COL_STEP:     cfg_q.col_step_q16  <= pwdata[COL_STEP_W-1:0];
				REG_DEST_COLS:    cfg_q.dest_cols     <= pwdata[DEST_COLS_W-1:0];
				REG_ROW_SCALE:    cfg_q.row_scale_q16 <= pwdata[ROW_SCALE_W-1:0];
				REG_DEST_LEFT:    cfg_q.dest_left     <= pwdata[OFFSET_W-1:0];
				REG_DEST_TOP:     cfg_q.dest_top      <= pwdata[OFFSET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (idx)
			REG_SOURCE_WIDTH: prdata = 32'(cfg_q.source_width);
			REG_COL_STEP:     prdata = 32'(cfg_q.col_step_q16);
			REG_DEST_COLS:    prdata = 32'(cfg_q.dest_cols);
			REG_ROW_SCALE:    prdata = 32'(cfg_q.row_scale_q16);
			REG_DEST_LEFT:    prdata = 32'(cfg_q.dest_left);
			REG_DEST_TOP:     prdata = 32'(cfg_q.dest_top);
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/ndg_front.sv =====
// ----------------------------------------------------------------------------
// ndg_front
// Counts source column and row, makes the row and column sampling decisions
// and pushes each sampled pixel with its destination coordinates.
// ----------------------------------------------------------------------------
module ndg_front #(
	parameter int MAX_DIM = ndg_pkg::MAX_DIM_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ndg_pkg::cfg_t               cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ndg_pkg::PIXEL_W-1:0] pixel_rgb565,
	input  logic                        start_of_image,
	input  logic                        q_full,
	output logic                        push,
	output ndg_pkg::q_item_t            push_item
);
	import ndg_pkg::*;

	localparam int CW  = $clog2(MAX_DIM);
	localparam int OCW = $clog2(MAX_DIM + 1);
	localparam int PW  = CW + ROW_SCALE_W;

	logic [CW-1:0]       src_col_q;
	logic [CW-1:0]       src_row_q;
	logic [OCW-1:0]      out_col_q;
	logic [SAMPLE_W-1:0] next_sample_q;
	logic                row_drawn_q;
	logic                last_row_valid_q;
	logic [COORD_W-1:0]  last_dest_row_q;

	logic                accept;
	logic [CW-1:0]       col;
	logic [CW-1:0]       row;
	logic                lv;
	logic [ROW_SCALE_W-1:0] scale_eff;
	logic [PW-1:0]       prod;
	logic [COORD_W-1:0]  drow;
	logic                drawn;
	logic                lv_n;
	logic [COORD_W-1:0]  ldr;
	logic [OCW-1:0]      oc;
	logic [SAMPLE_W-1:0] ns;
	logic [31:0]         w_eff;
	logic [31:0]         cols_eff;
	logic [SAMPLE_W-1:0] step_eff;
	logic [SAMPLE_W:0]   nxt;
	logic                emit;
	logic                row_wrap;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Clamp the configuration to its legal range
	always_comb begin
		if (cfg.source_width == '0) begin
			w_eff = 32'd1;
		end else if (32'(cfg.source_width) > 32'(MAX_DIM)) begin
			w_eff = 32'(MAX_DIM);
		end else begin
			w_eff = 32'(cfg.source_width);
		end
		cols_eff  = (32'(cfg.dest_cols) > 32'(MAX_DIM)) ? 32'(MAX_DIM) : 32'(cfg.dest_cols);
		step_eff  = (32'(cfg.col_step_q16) < 32'(ONE_Q16)) ? SAMPLE_W'(ONE_Q16)
			: SAMPLE_W'(cfg.col_step_q16);
		scale_eff = (32'(cfg.row_scale_q16) > 32'(ONE_Q16)) ? ROW_SCALE_W'(ONE_Q16)
			: cfg.row_scale_q16;
	end

	// Decide the row at column zero, then the column sample
	always_comb begin
		col  = start_of_image ? '0 : src_col_q;
		row  = start_of_image ? '0 : src_row_q;
		lv   = start_of_image ? 1'b0 : last_row_valid_q;
		prod = PW'(row) * PW'(scale_eff);
		drow = COORD_W'(32'(cfg.dest_top) + 32'(prod[PW-1:16]));
		if (col == '0) begin
			drawn = !(lv && (drow == last_dest_row_q));
			ldr   = drawn ? drow : last_dest_row_q;
			lv_n  = lv || drawn;
			oc    = '0;
			ns    = '0;
		end else begin
			drawn = row_drawn_q;
			ldr   = last_dest_row_q;
			lv_n  = lv;
			oc    = out_col_q;
			ns    = next_sample_q;
		end
		emit     = drawn && (32'(oc) < cols_eff) && (32'(ns[SAMPLE_W-1:16]) == 32'(col));
		nxt      = (SAMPLE_W+1)'(ns) + (SAMPLE_W+1)'(step_eff);
		row_wrap = (32'(col) + 32'd1) >= w_eff;
	end

	// Hand the sample to the queue
	assign push             = accept && emit;
	assign push_item.dest_x = COORD_W'(32'(cfg.dest_left) + 32'(oc));
	assign push_item.dest_y = ldr;
	assign push_item.pixel  = pixel_rgb565;

	// Advance the counters on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q        <= '0;
			src_row_q        <= '0;
			out_col_q        <= '0;
			next_sample_q    <= '0;
			row_drawn_q      <= 1'b0;
			last_row_valid_q <= 1'b0;
			last_dest_row_q  <= '0;
		end else if (accept) begin
			row_drawn_q      <= drawn;
			last_row_valid_q <= lv_n;
			last_dest_row_q  <= ldr;
			if (emit) begin
				out_col_q     <= oc + OCW'(1);
				next_sample_q <= (nxt > (SAMPLE_W+1)'(SAMPLE_MAX)) ? SAMPLE_W'(SAMPLE_MAX)
					: nxt[SAMPLE_W-1:0];
			end else begin
				out_col_q     <= oc;
				next_sample_q <= ns;
			end
			if (row_wrap) begin
				src_col_q <= '0;
				if ((32'(row) + 32'd1) < 32'(MAX_DIM)) begin
					src_row_q <= row + CW'(1);
				end else begin
					src_row_q <= row;
				end
			end else begin
				src_col_q <= col + CW'(1);
				src_row_q <= row;
			end
		end
	end

endmodule

// ===== rtl/core/ndg_queue.sv =====
// ----------------------------------------------------------------------------
// ndg_queue
// Short first-in first-out queue that parts the front from the back.
// ----------------------------------------------------------------------------
`include "nearest_downscale_gray_defines.svh"

module ndg_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ndg_pkg::q_item_t push_item,
	input  logic             pop,
	output logic             full,
	output logic             valid,
	output ndg_pkg::q_item_t head_item
);
	import ndg_pkg::*;

	q_item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign valid     = (count_q != '0);
	assign head_item = mem_q[rd_ptr_q];

	// Store the pushed beat
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	`NDG_ASSERT_ALWAYS(a_no_push_full, !(push && full), "push into a full queue")
	`NDG_ASSERT_ALWAYS(a_no_pop_empty, !(pop && !valid), "pop from an empty queue")
	`NDG_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + QCNT_W'(1), "count did not rise on push")
	`NDG_ASSERT_NEXT(a_count_down, pop && !push, count_q == $past(count_q) - QCNT_W'(1), "count did not fall on pop")

endmodule

// ===== rtl/core/ndg_back.sv =====
// ----------------------------------------------------------------------------
// ndg_back
// Converts the queued sample to gray and holds it in the output register.
// ----------------------------------------------------------------------------
module ndg_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  ndg_pkg::q_item_t            q_item,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ndg_pkg::COORD_W-1:0] dest_x,
	output logic [ndg_pkg::COORD_W-1:0] dest_y,
	output logic [ndg_pkg::GRAY_W-1:0]  gray_level
);
	import ndg_pkg::*;

	logic               out_valid_q;
	logic [COORD_W-1:0] dest_x_q;
	logic [COORD_W-1:0] dest_y_q;
	logic [GRAY_W-1:0]  gray_q;

	// Take the head when the output register is free or drains this cycle
	assign q_pop = q_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the converted beat
	always_ff @(posedge clk) begin
		if (q_pop) begin
			dest_x_q <= q_item.dest_x;
			dest_y_q <= q_item.dest_y;
			gray_q   <= gray_of(q_item.pixel);
		end
	end

	assign out_valid  = out_valid_q;
	assign dest_x     = dest_x_q;
	assign dest_y     = dest_y_q;
	assign gray_level = gray_q;

endmodule

// ===== rtl/core/nearest_downscale_gray.sv =====
// ----------------------------------------------------------------------------
// nearest_downscale_gray: RGB565 nearest-neighbor downscaler to gray pixels
// Throughput: one source pixel per cycle while the queue is not full; a sampled
// pixel's result passes through the queue and is then loaded into the output
// register. A full queue stalls the input.
// Rate is set by the front's combinational row/column decision per pixel.
// Reset (arst_n low) clears counters, queue and output valid, and loads config defaults.
// ----------------------------------------------------------------------------
module nearest_downscale_gray #(
	parameter int MAX_DIM = ndg_pkg::MAX_DIM_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [4:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ndg_pkg::PIXEL_W-1:0] pixel_rgb565,
	input  logic                        start_of_image,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ndg_pkg::COORD_W-1:0] dest_x,
	output logic [ndg_pkg::COORD_W-1:0] dest_y,
	output logic [ndg_pkg::GRAY_W-1:0]  gray_level
);
	import ndg_pkg::*;

	cfg_t    cfg;
	logic    push;
	q_item_t push_item;
	logic    q_full;
	logic    q_valid;
	logic    q_pop;
	q_item_t q_item;

	// Configuration registers
	ndg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Accept and classify pixels
	ndg_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.pixel_rgb565   (pixel_rgb565),
		.start_of_image (start_of_image),
		.q_full         (q_full),
		.push           (push),
		.push_item      (push_item)
	);

	// Decouple front and back
	ndg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (q_pop),
		.full      (q_full),
		.valid     (q_valid),
		.head_item (q_item)
	);

	// Convert and present results
	ndg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.dest_x     (dest_x),
		.dest_y     (dest_y),
		.gray_level (gray_level)
	);

endmodule

// ===== tb/tb_nearest_downscale_gray.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_downscale_gray
// Self-checking bench for the RGB565 downscaler. A short sequence of register
// writes and pixel beats covers the corner cases, then random images with
// random register settings run against a cycle-free model of the scaler.
// Each gray pixel leaving the block is matched, field by field, with the
// oldest predicted one. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_nearest_downscale_gray;
	import ndg_pkg::*;

	localparam int MAX_DIM       = MAX_DIM_DEF;
	localparam int RANDOM_BEATS  = 1150;
	localparam int LONG_BEATS    = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DIR_ROWS      = 42;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [GRAY_W-1:0]  level;
	} gray_px_t;

	typedef enum logic [1:0] {DIR_CFG, DIR_BEAT, DIR_EMIT, DIR_QUIET} dir_kind_t;
	typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

	typedef struct packed {
		dir_kind_t          kind;
		reg_idx_t           reg_sel;
		logic [31:0]        value;
		logic [PIXEL_W-1:0] pix;
		logic               sof;
		gray_px_t           px;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [4:0]           paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [PIXEL_W-1:0]   pixel_rgb565 = '0;
	logic                 start_of_image = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [COORD_W-1:0]   dest_x;
	logic [COORD_W-1:0]   dest_y;
	logic [GRAY_W-1:0]    gray_level;

	// Scaler model: register shadow and counters
	cfg_t                 cfg_shadow;
	logic [11:0]          m_col;
	logic [11:0]          m_row;
	logic [12:0]          m_ocol;
	logic [29:0]          m_next;
	logic [12:0]          m_last_row;
	bit                   m_drawn;
	bit                   m_last_valid;

	gray_px_t             expected_px[$];
	int                   errors = 0;
	int                   px_checked = 0;
	int                   beats_sent = 0;
	int                   random_beats = 0;
	int                   reg_writes = 0;
	int                   rx_holds = 0;
	int                   burst_left = 0;
	int                   cycles = 0;
	bit                   rx_hold_req = 1'b0;

	dir_row_t dir_seq [DIR_ROWS] = '{
		// plain 4x4 copy, extremes of each channel
		'{DIR_CFG,   REG_SOURCE_WIDTH, 32'd4,    16'h0000, 1'b0, '0},
		'{DIR_CFG,   REG_DEST_COLS,    32'd4,    16'h0000, 1'b0, '0},
		'{DIR_EMIT,  REG_SOURCE_WIDTH, 32'd0,    16'h0000, 1'b1, '{13'd0, 13'd0, 8'd0}},
		'{DIR_EMIT,  REG_SOURCE_WIDTH, 32'd0,    16'hFFFF, 1'b0, '{13'd1, 13'd0, 8'd250}},
		'{DIR_EMIT,  REG_SOURCE_WIDTH, 32'd0,    16'hF800, 1'b0, '{13'd2, 13'd0, 8'd73}},
		'{DIR_EMIT,  REG_SOURCE_WIDTH, 32'd0,    16'h07E0, 1'b0, '{13'd3, 13'd0, 8'd147}},
		'{DIR_EMIT,  REG_SOURCE_WIDTH, 32'd0,    16'h001F, 1'b0, '{13'd0, 13'd1, 8'd29}},
		'{DIR_BEAT,  REG_SOURCE_WIDTH, 32'd0,    16'h1234, 1'b0, '0},
		// restart of the image in the middle of a row
		'{DIR_BEAT,  REG_SOURCE_WIDTH, 32'd0,    16'h0841, 1'b1, '0},
		'{DIR_BEAT,  REG_SOURCE_WIDTH, 32'd0,    16'hABCD, 1'b0, '0},
		'{DIR_BEAT,  REG_SOURCE_WIDTH, 32'd0,    16'h8000, 1'b0, '0},
		'{DIR_BEAT,  REG_SOURCE_WIDTH, 32'd0,    16'h5555, 1'b0, '0},
		'{DIR_BEAT,  REG_SOURCE_WIDTH, 32'd0,    16'hAAAA, 1'b0, '0},
		'{DIR_BEAT,  REG_SOURCE_WIDTH, 32'd0,    16'h7BEF, 1'b0, '0},
		// zero width, zero step, column count past the limit, zero row scale
		'{DIR_CFG,   REG_SOURCE_WIDTH, 32'd0,    16'h0000, 1'b0, '0},
		'{DIR_CFG,   REG_COL_STEP,     32'd0,    16'h0000, 1'b0, '0},
		'{DIR_CFG,   REG_DEST_COLS,    32'd8191, 16'h0000, 1'b0, '0},
		'{DIR_CFG,   REG_ROW_SCALE,    32'd0,    16'h0000, 1'b0, '0},
		'{DIR_CFG,   REG_DEST_LEFT,    32'd4095, 16'h0000, 1'b0, '0},
		'{DIR_CFG,   REG_DEST_TOP,     32'd4095, 16'h0000, 1'b0, '0},
		'{DIR_EMIT,  REG_SOURCE_WIDTH, 32'd0,    16'hFFFF, 1'b1,
			'{13'd4095, 13'd4095, 8'd250}},
		'{DIR_QUIET, REG_SOURCE_WIDTH, 32'd0,    16'h0000, 1'b0, '0},
		'{DIR_QUIET, REG_SOURCE_WIDTH, 32'd0,    16'hFFFF, 1'b0, '0},
		'{DIR_QUIET, REG_SOURCE_WIDTH, 32'd0,    16'h1234, 1'b0, '0},
		'{DIR_QUIET, REG_SOURCE_WIDTH, 32'd0,    16'hF81F, 1'b0, '0},
		'{DIR_EMIT,  REG_SOURCE_WIDTH, 32'd0,    16'h07E0, 1'b1,
			'{13'd4095, 13'd4095, 8'd147}},
		// step of two, row scale past 1.0, a sample position past the row end
		'{DIR_CFG,   REG_SOURCE_WIDTH, 32'd3,      16'h0000, 1'b0, '0},
		'{DIR_CFG,   REG_COL_STEP,     32'h20000,  16'h0000, 1'b0, '0},
		'{DIR_CFG,   REG_DEST_COLS,    32'd3,      16'h0000, 1'b0, '0},
		'{DIR_CFG,   REG_ROW_SCALE,    32'd131071, 16'h0000, 1'b0, '0},
		'{DIR_CFG,   REG_DEST_LEFT,    32'd4094,   16'h0000, 1'b0, '0},
		'{DIR_CFG,   REG_DEST_TOP,     32'd0,      16'h0000, 1'b0, '0},
		'{DIR_BEAT,  REG_SOURCE_WIDTH, 32'd0,    16'hF800, 1'b1, '0},
		'{DIR_BEAT,  REG_SOURCE_WIDTH, 32'd0,    16'h0000, 1'b0, '0},
		'{DIR_BEAT,  REG_SOURCE_WIDTH, 32'd0,    16'h07E0, 1'b0, '0},
		'{DIR_BEAT,  REG_SOURCE_WIDTH, 32'd0,    16'h001F, 1'b0, '0},
		'{DIR_BEAT,  REG_SOURCE_WIDTH, 32'd0,    16'hC618, 1'b0, '0},
		'{DIR_BEAT,  REG_SOURCE_WIDTH, 32'd0,    16'h39E7, 1'b0, '0},
		'{DIR_BEAT,  REG_SOURCE_WIDTH, 32'd0,    16'hFFE0, 1'b0, '0},
		'{DIR_BEAT,  REG_SOURCE_WIDTH, 32'd0,    16'h001F, 1'b0, '0},
		'{DIR_BEAT,  REG_SOURCE_WIDTH, 32'd0,    16'hF81F, 1'b0, '0},
		'{DIR_BEAT,  REG_SOURCE_WIDTH, 32'd0,    16'h07FF, 1'b0, '0}
	};

	nearest_downscale_gray #(
		.MAX_DIM(MAX_DIM)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel_rgb565(pixel_rgb565),
		.start_of_image(start_of_image),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dest_x(dest_x),
		.dest_y(dest_y),
		.gray_level(gray_level)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Weighted luminance from the widened 565 channels
	function automatic logic [GRAY_W-1:0] luma565(input logic [PIXEL_W-1:0] p);
		int unsigned sum;
		sum = {p[15:11], 3'b000} * GRAY_WR + {p[10:5], 2'b00} * GRAY_WG
			+ {p[4:0], 3'b000} * GRAY_WB;
		return GRAY_W'(sum >> GRAY_SHIFT);
	endfunction

	// Advance the scaler model by one source pixel
	task automatic scale_pixel(input logic [PIXEL_W-1:0] pix, input bit sof,
			output bit hit, output gray_px_t px);
		int unsigned scale;
		int unsigned cols;
		int unsigned step;
		int unsigned width;
		longint unsigned nxt;
		logic [12:0] drow;
		hit = 1'b0;
		px = '0;
		if (sof) begin
			m_col = '0;
			m_row = '0;
			m_last_valid = 1'b0;
		end
		// row decision at the first column
		if (m_col == 0) begin
			scale = (cfg_shadow.row_scale_q16 > ONE_Q16) ? ONE_Q16 : cfg_shadow.row_scale_q16;
			drow = cfg_shadow.dest_top + ((m_row * scale) >> 16);
			m_drawn = !(m_last_valid && drow == m_last_row);
			if (m_drawn) begin
				m_last_row = drow;
				m_last_valid = 1'b1;
			end
			m_ocol = '0;
			m_next = '0;
		end
		// sample the column that the running position points at
		cols = (cfg_shadow.dest_cols > MAX_DIM) ? MAX_DIM : cfg_shadow.dest_cols;
		if (m_drawn && m_ocol < cols && m_next[29:16] == m_col) begin
			step = (cfg_shadow.col_step_q16 < ONE_Q16) ? ONE_Q16 : cfg_shadow.col_step_q16;
			nxt = longint'(m_next) + step;
			hit = 1'b1;
			px.x = cfg_shadow.dest_left + m_ocol;
			px.y = m_last_row;
			px.level = luma565(pix);
			m_ocol = m_ocol + 1'b1;
			m_next = (nxt > SAMPLE_MAX) ? 30'(SAMPLE_MAX) : 30'(nxt);
		end
		// advance source column and row
		width = cfg_shadow.source_width;
		if (width == 0)
			width = 1;
		if (width > MAX_DIM)
			width = MAX_DIM;
		if (int'(m_col) + 1 >= width) begin
			m_col = '0;
			if (int'(m_row) + 1 < MAX_DIM)
				m_row = m_row + 1'b1;
		end else begin
			m_col = m_col + 1'b1;
		end
	endtask

	// Drop valid, wait for every gray pixel to come out, then let the pipe settle
	task automatic settle_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_px.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write on the APB port, only once the stream is idle
	task automatic apb_write_reg(input reg_idx_t idx, input logic [31:0] val);
		settle_idle();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SOURCE_WIDTH: cfg_shadow.source_width  = val[SRC_WIDTH_W-1:0];
			REG_COL_STEP:     cfg_shadow.col_step_q16  = val[COL_STEP_W-1:0];
			REG_DEST_COLS:    cfg_shadow.dest_cols     = val[DEST_COLS_W-1:0];
			REG_ROW_SCALE:    cfg_shadow.row_scale_q16 = val[ROW_SCALE_W-1:0];
			REG_DEST_LEFT:    cfg_shadow.dest_left     = val[OFFSET_W-1:0];
			REG_DEST_TOP:     cfg_shadow.dest_top      = val[OFFSET_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// Offer one pixel beat, in bursts with random gaps; predict at acceptance
	task automatic send_beat(input logic [PIXEL_W-1:0] pix, input bit sof,
			input bit typed, input bit typed_hit, input gray_px_t typed_px);
		int gap;
		bit hit;
		gray_px_t px;
		if (burst_left == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(100, 300);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 40);
				gap = $urandom_range(1, 8);
			end
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		pixel_rgb565 <= pix;
		start_of_image <= sof;
		do @(posedge clk); while (!in_ready);
		scale_pixel(pix, sof, hit, px);
		if (typed) begin
			hit = typed_hit;
			px = typed_px;
		end
		if (hit)
			expected_px.push_back(px);
		beats_sent++;
	endtask

	// One image under a random register setting; dense ones fill the pipe
	task automatic random_image(input bit dense);
		int unsigned w;
		int unsigned w_eff;
		int unsigned step;
		int unsigned step_eff;
		int unsigned cols;
		int unsigned scale;
		int unsigned rows;
		int unsigned n;
		int unsigned k;
		int unsigned sel;
		bit sof;
		sel = $urandom_range(0, 9);
		w = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(25, 64) : $urandom_range(1, 24);
		w_eff = (w == 0) ? 1 : w;
		sel = $urandom_range(0, 15);
		if (sel == 0)
			step = $urandom_range(0, ONE_Q16 - 1);
		else if (sel == 1)
			step = $urandom() & 32'h1FFF_FFFF;
		else
			step = $urandom_range(ONE_Q16, 4 * ONE_Q16);
		step_eff = (step < ONE_Q16) ? ONE_Q16 : step;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			cols = $urandom_range(0, w_eff + 4);
		else if (sel == 1)
			cols = $urandom_range(4096, 8191);
		else
			cols = (w_eff * ONE_Q16 + step_eff - 1) / step_eff;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			scale = 0;
		else if (sel == 1)
			scale = $urandom_range(ONE_Q16 + 1, 131071);
		else
			scale = $urandom_range(1, ONE_Q16);
		rows = $urandom_range(1, 10);
		if (dense) begin
			w = $urandom_range(8, 24);
			w_eff = w;
			step = ONE_Q16;
			cols = w;
			scale = ONE_Q16;
			rows = $urandom_range(4, 8);
		end
		apb_write_reg(REG_SOURCE_WIDTH, w);
		apb_write_reg(REG_COL_STEP, step);
		apb_write_reg(REG_DEST_COLS, cols);
		apb_write_reg(REG_ROW_SCALE, scale);
		apb_write_reg(REG_DEST_LEFT, $urandom_range(0, 4095));
		apb_write_reg(REG_DEST_TOP, $urandom_range(0, 4095));
		if (dense) begin
			rx_hold_req = 1'b1;
			rx_holds++;
		end
		n = w_eff * rows;
		// now and then cut the image short
		if (!dense && $urandom_range(0, 9) == 0)
			n = $urandom_range(1, n);
		for (k = 0; k < n; k++) begin
			sof = (k == 0) || (!dense && $urandom_range(0, 59) == 0);
			send_beat($urandom_range(0, 65535), sof, 1'b0, 1'b0, '0);
		end
		random_beats += n;
	endtask

	// Long first row under a source width past MAX_DIM; every pixel is sampled
	task automatic long_image(input int unsigned w, input int unsigned nbeats, input bit hold);
		int unsigned k;
		apb_write_reg(REG_SOURCE_WIDTH, w);
		apb_write_reg(REG_COL_STEP, ONE_Q16);
		apb_write_reg(REG_DEST_COLS, 32'd8191);
		apb_write_reg(REG_ROW_SCALE, ONE_Q16);
		apb_write_reg(REG_DEST_LEFT, $urandom_range(0, 4095));
		apb_write_reg(REG_DEST_TOP, $urandom_range(0, 4095));
		if (hold) begin
			rx_hold_req = 1'b1;
			rx_holds++;
		end
		for (k = 0; k < nbeats; k++)
			send_beat($urandom_range(0, 65535), k == 0, 1'b0, 1'b0, '0);
	endtask

	// Receiver: long hold-off on request, otherwise free, random or patterned stalls
	initial begin
		rx_mode_t mode;
		int mode_left;
		int hold_cnt;
		mode = RX_FREE;
		mode_left = 0;
		hold_cnt = 0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				out_ready <= 1'b0;
				hold_cnt++;
				if (hold_cnt >= RX_HOLD_CYCLES) begin
					rx_hold_req = 1'b0;
					hold_cnt = 0;
				end
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(16, 160);
				end
				mode_left--;
				case (mode)
					RX_FREE:   out_ready <= 1'b1;
					RX_RANDOM: out_ready <= ($urandom_range(0, 99) >= 35);
					default:   out_ready <= ((mode_left % 5) < 3);
				endcase
			end
		end
	end

	// Match each gray pixel beat against the oldest prediction
	always @(posedge clk) begin
		gray_px_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_px.size() == 0) begin
				$error("unexpected gray pixel: dest_x %0d dest_y %0d gray_level %0d",
					dest_x, dest_y, gray_level);
				errors++;
			end else begin
				want = expected_px.pop_front();
				if (dest_x !== want.x) begin
					$error("dest_x: expected %0d, got %0d", want.x, dest_x);
					errors++;
				end
				if (dest_y !== want.y) begin
					$error("dest_y: expected %0d, got %0d", want.y, dest_y);
					errors++;
				end
				if (gray_level !== want.level) begin
					$error("gray_level: expected %0d, got %0d", want.level, gray_level);
					errors++;
				end
				px_checked++;
			end
		end
	end

	// Watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles, %0d gray pixels still pending",
			cycles, expected_px.size());
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int k;
		int img;
		cfg_shadow.source_width = 1;
		cfg_shadow.col_step_q16 = ONE_Q16;
		cfg_shadow.dest_cols = 0;
		cfg_shadow.row_scale_q16 = ONE_Q16;
		cfg_shadow.dest_left = 0;
		cfg_shadow.dest_top = 0;
		m_col = '0;
		m_row = '0;
		m_ocol = '0;
		m_next = '0;
		m_last_row = '0;
		m_drawn = 1'b0;
		m_last_valid = 1'b0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed corner cases
		for (k = 0; k < DIR_ROWS; k++) begin
			case (dir_seq[k].kind)
				DIR_CFG:  apb_write_reg(dir_seq[k].reg_sel, dir_seq[k].value);
				DIR_BEAT: send_beat(dir_seq[k].pix, dir_seq[k].sof, 1'b0, 1'b0, '0);
				default:  send_beat(dir_seq[k].pix, dir_seq[k].sof, 1'b1,
					dir_seq[k].kind == DIR_EMIT, dir_seq[k].px);
			endcase
		end

		// random images, two of them dense under a long output hold-off
		img = 0;
		while (random_beats < RANDOM_BEATS) begin
			img++;
			random_image(img == 3 || img == 10);
		end

		// source row wider than MAX_DIM under a long output hold-off
		long_image(32'd8191, LONG_BEATS, 1'b1);

		settle_idle();
		$display("Covered %0d pixel beats (%0d in random images), %0d gray pixels checked,",
			beats_sent, random_beats, px_checked);
		$display("%0d register writes and %0d long output hold-offs.", reg_writes, rx_holds);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
